// ===== rtl/vcmp_pkg.sv =====
// Shared types, widths and codes of the voxel corner material packer.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package vcmp_pkg;

  localparam int CELL_W  = 11;
  localparam int OP_W    = 2;
  localparam int VOX_W   = 16;
  localparam int KEY_W   = 8;
  localparam int PT_W    = 16;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 2;
  localparam int PLANE_W = 2 * CELL_W;
  localparam int TOTAL_W = 3 * CELL_W;
  localparam int POINT_W = TOTAL_W + 1;
  localparam int SLOT_W  = 3;
  localparam int SH_W    = 7;

  localparam int DEF_TABLE_DEPTH = 65536;
  localparam int DEF_KEY_BITS    = 4;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_CELLS_Z = 2'd2;

  typedef struct packed {
    logic capture;
    logic calc_plane;
    logic calc_total;
    logic set_err;
    logic div_start;
    logic div_sel;
    logic cap_z;
    logic cap_xy;
    logic calc_terms;
    logic calc_point;
    logic rd_corner;
    logic wr_corner;
    logic rd_point;
    logic cap_word;
    logic clr_start;
    logic clr_write;
    logic load_result;
  } vcmp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic vox_err;
    logic pt_err;
    logic div_done;
    logic clr_last;
    logic slot_last;
    logic out_busy;
  } vcmp_status_t;

endpackage

`default_nettype wire

// ===== rtl/vcmp_if.sv =====
// Request and result channel interfaces of the voxel corner material packer.
// Depends on vcmp_pkg for the field widths.
`default_nettype none

interface vcmp_req_if import vcmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [VOX_W-1:0]  voxel_index;
  logic [KEY_W-1:0]  material_key;
  logic [PT_W-1:0]   point_index;

  modport source (output valid, operation, voxel_index, material_key, point_index,
                  input ready);
  modport sink (input valid, operation, voxel_index, material_key, point_index,
                output ready);
endinterface

interface vcmp_res_if import vcmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;
  logic              index_error;

  modport source (output valid, packed_word, index_error, input ready);
  modport sink (input valid, packed_word, index_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/vcmp_divider.sv =====
// Restoring divider that retires one quotient bit per cycle.
// Depends on vcmp_pkg for the dividend and divisor widths.
`default_nettype none

module vcmp_divider import vcmp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [VOX_W-1:0]   dividend,
  input  wire logic [PLANE_W-1:0] divisor,
  output logic      [VOX_W-1:0]   quotient,
  output logic      [PLANE_W-1:0] remainder,
  output logic                    done
);

  localparam int CNT_W = $clog2(VOX_W + 1);

  logic [VOX_W-1:0]   quo;
  logic [PLANE_W-1:0] rem;
  logic [PLANE_W-1:0] dsr;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [PLANE_W:0]   trial;
  logic [PLANE_W:0]   diff;
  logic               fits;

  assign trial = {rem, quo[VOX_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VOX_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[PLANE_W-1:0] : trial[PLANE_W-1:0];
      quo <= {quo[VOX_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== rtl/vcmp_datapath.sv =====
// Datapath of the voxel corner material packer: cell registers, index arithmetic,
// the point table memory and the result register. Depends on vcmp_pkg and vcmp_divider.
`default_nettype none

module vcmp_datapath import vcmp_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_index,
  input  wire logic [CELL_W-1:0]   wr_data,
  input  wire logic [OP_W-1:0]     operation,
  input  wire logic [VOX_W-1:0]    voxel_index,
  input  wire logic [KEY_W-1:0]    material_key,
  input  wire logic [PT_W-1:0]     point_index,
  input  wire logic                out_ready,
  input  wire vcmp_cmd_t           cmd,
  output vcmp_status_t             status,
  output logic                     out_valid,
  output logic      [WORD_W-1:0]   out_word,
  output logic                     out_err
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [CELL_W-1:0]   cells_x;
  logic [CELL_W-1:0]   cells_y;
  logic [CELL_W-1:0]   cells_z;
  op_t                 op_q;
  logic [VOX_W-1:0]    vox_q;
  logic [KEY_BITS-1:0] key_q;
  logic [PT_W-1:0]     pt_q;
  logic [PLANE_W-1:0]  plane;
  logic [TOTAL_W-1:0]  total;
  logic [CELL_W-1:0]   x, y, z, x1, y1, z1;
  logic [TOTAL_W-1:0]  zt0, zt1;
  logic [PLANE_W-1:0]  xt0, xt1;
  logic [SLOT_W-1:0]   slot;
  logic [POINT_W-1:0]  point;
  logic [WORD_W-1:0]   addend;
  logic [WORD_W-1:0]   rdata;
  logic [WORD_W-1:0]   word_q;
  logic                err_q;
  logic [ADDR_W-1:0]   clr_cnt;
  logic                clr_last;

  logic [VOX_W-1:0]    div_dividend;
  logic [PLANE_W-1:0]  div_divisor;
  logic [VOX_W-1:0]    div_quo;
  logic [PLANE_W-1:0]  div_rem;
  logic                div_done;

  logic [POINT_W-1:0]  pt_ext;
  logic                vox_err;
  logic                pt_err;
  logic                in_rng;
  logic                dx, dy;
  logic [63:0]         key_wide;

  logic [WORD_W-1:0]   mem [TABLE_DEPTH];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  function automatic logic [CELL_W-1:0] wrap_next(input logic [CELL_W-1:0] v,
                                                  input logic [CELL_W-1:0] n);
    logic [CELL_W:0] s;
    s = {1'b0, v} + (CELL_W+1)'(1);
    return (s >= {1'b0, n}) ? '0 : s[CELL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= CELL_W'(1);
      cells_y <= CELL_W'(1);
      cells_z <= CELL_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_CELLS_X: cells_x <= wr_data;
        REG_CELLS_Y: cells_y <= wr_data;
        REG_CELLS_Z: cells_z <= wr_data;
        default: ;
      endcase
    end
  end

  assign div_dividend = cmd.div_sel ? div_rem[VOX_W-1:0] : vox_q;
  assign div_divisor  = cmd.div_sel ? PLANE_W'(cells_y) : plane;

  vcmp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign pt_ext   = POINT_W'(pt_q);
  assign vox_err  = TOTAL_W'(vox_q) >= total;
  assign pt_err   = (TOTAL_W'(pt_q) >= total) || (pt_ext >= POINT_W'(TABLE_DEPTH));
  assign in_rng   = point < POINT_W'(TABLE_DEPTH);
  assign dx       = (slot[1:0] == 2'd1) || (slot[1:0] == 2'd2);
  assign dy       = (slot[1:0] == 2'd0) || (slot[1:0] == 2'd1);
  assign key_wide = 64'(key_q) << (SH_W'(slot) * SH_W'(KEY_BITS));
  assign clr_last = clr_cnt == ADDR_W'(TABLE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(operation);
      vox_q <= voxel_index;
      key_q <= material_key[KEY_BITS-1:0];
      pt_q  <= point_index;
    end
    if (cmd.calc_plane) begin
      plane <= PLANE_W'(cells_x) * PLANE_W'(cells_y);
    end
    if (cmd.calc_total) begin
      total <= TOTAL_W'(plane) * TOTAL_W'(cells_z);
    end
    if (cmd.cap_z) begin
      z  <= div_quo[CELL_W-1:0];
      z1 <= wrap_next(div_quo[CELL_W-1:0], cells_z);
    end
    if (cmd.cap_xy) begin
      x  <= div_quo[CELL_W-1:0];
      x1 <= wrap_next(div_quo[CELL_W-1:0], cells_x);
      y  <= div_rem[CELL_W-1:0];
      y1 <= wrap_next(div_rem[CELL_W-1:0], cells_y);
    end
    if (cmd.calc_terms) begin
      zt0 <= TOTAL_W'(z) * TOTAL_W'(plane);
      zt1 <= TOTAL_W'(z1) * TOTAL_W'(plane);
      xt0 <= PLANE_W'(x) * PLANE_W'(cells_y);
      xt1 <= PLANE_W'(x1) * PLANE_W'(cells_y);
    end
    if (cmd.calc_point) begin
      point  <= POINT_W'(slot[2] ? zt1 : zt0) + POINT_W'(dx ? xt1 : xt0)
              + POINT_W'(dy ? y1 : y);
      addend <= key_wide[WORD_W-1:0];
    end
    if (cmd.capture) begin
      word_q <= '0;
    end else if (cmd.cap_word) begin
      word_q <= rdata;
    end
    if (cmd.capture) begin
      err_q <= 1'b0;
    end else if (cmd.set_err) begin
      err_q <= ((op_q == OP_ACCUM) && vox_err) || ((op_q == OP_READ) && pt_err);
    end
    if (cmd.load_result) begin
      out_word <= word_q;
      out_err  <= err_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        slot <= '0;
      end else if (cmd.wr_corner) begin
        slot <= slot + SLOT_W'(1);
      end
      if (cmd.clr_start) begin
        clr_cnt <= '0;
      end else if (cmd.clr_write) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + ADDR_W'(1);
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we    = cmd.clr_write || (cmd.wr_corner && in_rng);
    mem_waddr = cmd.clr_write ? clr_cnt : point[ADDR_W-1:0];
    mem_wdata = cmd.clr_write ? '0 : rdata + addend;
    mem_re    = (cmd.rd_corner && in_rng) || cmd.rd_point;
    mem_raddr = cmd.rd_point ? pt_ext[ADDR_W-1:0] : point[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    status.op        = op_q;
    status.vox_err   = vox_err;
    status.pt_err    = pt_err;
    status.div_done  = div_done;
    status.clr_last  = clr_last;
    status.slot_last = slot == SLOT_W'(7);
    status.out_busy  = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/vcmp_ctrl.sv =====
// Controller state machine of the voxel corner material packer.
// Depends on vcmp_pkg for the command and status structs and the operation codes.
`default_nettype none

module vcmp_ctrl import vcmp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire vcmp_status_t status,
  output vcmp_cmd_t         cmd
);

  typedef enum logic [13:0] {
    S_INIT   = 14'h0001,
    S_IDLE   = 14'h0002,
    S_PLANE  = 14'h0004,
    S_TOTAL  = 14'h0008,
    S_DECIDE = 14'h0010,
    S_CLEAR  = 14'h0020,
    S_DIV_Z  = 14'h0040,
    S_DIV_X  = 14'h0080,
    S_TERMS  = 14'h0100,
    S_CADDR  = 14'h0200,
    S_CRD    = 14'h0400,
    S_CWR    = 14'h0800,
    S_RDATA  = 14'h1000,
    S_DONE   = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.clr_write = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PLANE;
        end
      end
      S_PLANE: begin
        cmd.calc_plane = 1'b1;
        state_next     = S_TOTAL;
      end
      S_TOTAL: begin
        cmd.calc_total = 1'b1;
        state_next     = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.set_err = 1'b1;
        case (status.op)
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = S_CLEAR;
          end
          OP_ACCUM: begin
            if (status.vox_err) begin
              state_next = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV_Z;
            end
          end
          OP_READ: begin
            if (status.pt_err) begin
              state_next = S_DONE;
            end else begin
              cmd.rd_point = 1'b1;
              state_next   = S_RDATA;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_last) begin
          state_next = S_DONE;
        end
      end
      S_DIV_Z: begin
        if (status.div_done) begin
          cmd.cap_z     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (status.div_done) begin
          cmd.cap_xy = 1'b1;
          state_next = S_TERMS;
        end
      end
      S_TERMS: begin
        cmd.calc_terms = 1'b1;
        state_next     = S_CADDR;
      end
      S_CADDR: begin
        cmd.calc_point = 1'b1;
        state_next     = S_CRD;
      end
      S_CRD: begin
        cmd.rd_corner = 1'b1;
        state_next    = S_CWR;
      end
      S_CWR: begin
        cmd.wr_corner = 1'b1;
        state_next    = status.slot_last ? S_DONE : S_CADDR;
      end
      S_RDATA: begin
        cmd.cap_word = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/voxel_corner_material_packer_core.sv =====
// Top level of the voxel corner material packer: controller, datapath and ports.
// Depends on vcmp_pkg, vcmp_if, vcmp_ctrl and vcmp_datapath.
//
// The block keeps one 32-bit word per periodic grid point in a table of
// TABLE_DEPTH words with separate read and write ports and handles one request
// at a time. After reset it sweeps the table to zero, one word per cycle, before
// the first request is accepted; configuration writes are taken during that
// sweep. A clear request repeats the sweep. In an accumulate the voxel index is
// split by two 16-step serial divisions, and each of the eight corners then goes
// through address, table read and table write steps. The result sits in an
// output register, so the next request can start while it waits.
`default_nettype none

module voxel_corner_material_packer_core import vcmp_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_index,
  input  wire logic [CELL_W-1:0] wr_data,
  vcmp_req_if.sink               req,
  vcmp_res_if.source             res
);

  vcmp_cmd_t    cmd;
  vcmp_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic [WORD_W-1:0] out_word;
  logic         out_err;

  vcmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vcmp_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .operation    (req.operation),
    .voxel_index  (req.voxel_index),
    .material_key (req.material_key),
    .point_index  (req.point_index),
    .out_ready    (res.ready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_word     (out_word),
    .out_err      (out_err)
  );

  assign req.ready       = in_ready;
  assign res.valid       = out_valid;
  assign res.packed_word = out_word;
  assign res.index_error = out_err;

endmodule

`default_nettype wire

// ===== rtl/vcmp_checker.sv =====
// Port-level checker of the voxel corner material packer and its bind statement.
// Depends on the top level voxel_corner_material_packer_core and vcmp_pkg.
`default_nettype none

module vcmp_checker import vcmp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [WORD_W-1:0] packed_word,
  input wire logic              index_error
);

  // A stalled result keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(packed_word) && $stable(index_error))
    else $error("stalled result changed");

  // A flagged request never carries a table word.
  a_error_word_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> packed_word == '0)
    else $error("flagged result carries a nonzero word");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind voxel_corner_material_packer_core vcmp_checker u_vcmp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .packed_word (res.packed_word),
  .index_error (res.index_error)
);

`default_nettype wire
